// File: design/keyword_token_lexer_defines.svh
// assertion macros for the keyword token lexer
`ifndef KEYWORD_TOKEN_LEXER_DEFINES_SVH
`define KEYWORD_TOKEN_LEXER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KTL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define KTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ktl_pkg.sv
// shared types, constants and character functions of the keyword token lexer
package ktl_pkg;

	// position counter and keyword buffer sizes
	localparam int POS_W   = 16;
	localparam int KW_LEN  = 18;
	localparam int IDX_W   = $clog2(KW_LEN);
	localparam int OUT_W   = 16;
	localparam int NUM_KW  = 23;

	// token queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// lexer modes
	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_WORD    = 2'd1;
	localparam logic [1:0] MODE_STRING  = 2'd2;
	localparam logic [1:0] MODE_COMMENT = 2'd3;

	// token kinds
	localparam logic [5:0] KIND_END    = 6'd0;
	localparam logic [5:0] KIND_STRING = 6'd9;
	localparam logic [5:0] KIND_NUMBER = 6'd10;
	localparam logic [5:0] KIND_IDENT  = 6'd11;

	// special characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// keyword table, text right-aligned with zero fill
	localparam logic [8*KW_LEN-1:0] KW_TEXT [NUM_KW] = '{
		"pulse", "global", "shadow", "atom", "beam", "quantum", "vortex", "void",
		"synapse", "bypass", "chronos", "ether", "scan", "matrix", "~link", "fusion",
		"@NeuralComposition", "Signal", "Vision", "Orbit", "Trigger", "Z_Plane",
		"Input"
	};
	localparam int KW_LENS [NUM_KW] = '{
		5, 6, 6, 4, 4, 7, 6, 4, 7, 6, 7, 5, 4, 6, 5, 6, 18, 6, 6, 5, 7, 7, 5
	};
	localparam logic [5:0] KW_KINDS [NUM_KW] = '{
		6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
		6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29, 6'd30,
		6'd31, 6'd32, 6'd33
	};

	typedef logic [KW_LEN-1:0][7:0] prefix_t;

	// one result item without its run flag
	typedef struct packed {
		logic [5:0]       kind;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] len;
		logic             endm;
	} ktl_tok_t;

	// one queue entry: one or two tokens from one input item
	typedef struct packed {
		logic     two;
		ktl_tok_t tok0;
		ktl_tok_t tok1;
	} ktl_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} ktl_qstat_t;

	// saturating position increment
	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v == {POS_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// clip a position to the output width
	function automatic logic [OUT_W-1:0] clip_pos(input logic [POS_W-1:0] v);
		logic [POS_W+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		return (w > (POS_W+OUT_W)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
	endfunction

	// alphanumerics and _ . ~ @ #
	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == "_" || c == "." || c == "~" ||
			c == "@" || c == "#";
	endfunction

	// space, tab, newline and the other control blanks
	function automatic logic is_space_byte(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// punctuation lookup: {hit, kind}
	function automatic logic [6:0] punct_kind(input logic [7:0] c);
		logic [6:0] r;
		case (c)
			"{":     r = {1'b1, 6'd0};
			"}":     r = {1'b1, 6'd1};
			"[":     r = {1'b1, 6'd2};
			"]":     r = {1'b1, 6'd3};
			"(":     r = {1'b1, 6'd4};
			")":     r = {1'b1, 6'd5};
			":":     r = {1'b1, 6'd6};
			",":     r = {1'b1, 6'd7};
			"=":     r = {1'b1, 6'd8};
			default: r = '0;
		endcase
		return r;
	endfunction

	// keyword match against the prefix buffer, else number or identifier
	function automatic logic [5:0] word_kind(input prefix_t pre,
		input logic [POS_W-1:0] len);
		logic [5:0] k;
		logic       hit;
		logic       m;
		int         sh;
		logic [7:0] kb;
		k   = (pre[0] >= "0" && pre[0] <= "9") ? KIND_NUMBER : KIND_IDENT;
		hit = 1'b0;
		for (int w = 0; w < NUM_KW; w++) begin
			m = (len == POS_W'(KW_LENS[w]));
			for (int i = 0; i < KW_LEN; i++) begin
				sh = (i < KW_LENS[w]) ? 8 * (KW_LENS[w] - 1 - i) : 0;
				kb = 8'(KW_TEXT[w] >> sh);
				if (i < KW_LENS[w] && pre[i] != kb) begin
					m = 1'b0;
				end
			end
			if (m && !hit) begin
				hit = 1'b1;
				k   = KW_KINDS[w];
			end
		end
		return k;
	endfunction

endpackage

// File: design/ktl_fifo.sv
// short token queue between the lexer front and the result back
module ktl_fifo import ktl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  ktl_entry_t wr_data,
	input  logic       rd,
	output ktl_entry_t rd_data,
	output ktl_qstat_t stat
);

	ktl_entry_t      mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_AW:0]   cnt_q;

	// status and head entry
	assign stat.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/ktl_front.sv
// lexer front: takes bytes, tracks mode and word, classifies tokens
module ktl_front import ktl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] ch,
	input  logic       end_of_source,
	input  ktl_qstat_t q_stat,
	output logic       q_wr,
	output ktl_entry_t q_data
);

	logic [1:0]       mode_q, mode_d;
	logic             slash_q, slash_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] tstart_q, tstart_d;
	logic [POS_W-1:0] tlen_q, tlen_d;
	prefix_t          prefix_q;

	logic             acc;
	logic             handled;
	logic             pre_we;
	logic [IDX_W-1:0] pre_idx;
	logic             f_v, s_v;
	ktl_tok_t         f_tok, s_tok, word_tok, str_tok;
	logic [6:0]       pk;

	assign acc = push && !q_stat.full;
	assign pk  = punct_kind(ch);

	// flush tokens of the open word or string
	always_comb begin
		word_tok.kind  = word_kind(prefix_q, tlen_q);
		word_tok.start = clip_pos(tstart_q);
		word_tok.len   = clip_pos(tlen_q);
		word_tok.endm  = 1'b0;
		str_tok.kind   = KIND_STRING;
		str_tok.start  = clip_pos(tstart_q);
		str_tok.len    = clip_pos(tlen_q);
		str_tok.endm   = 1'b0;
	end

	// next state and the tokens of this item
	always_comb begin
		mode_d   = mode_q;
		slash_d  = slash_q;
		pos_d    = pos_q;
		tstart_d = tstart_q;
		tlen_d   = tlen_q;
		pre_we   = 1'b0;
		pre_idx  = '0;
		handled  = 1'b0;
		f_v      = 1'b0;
		f_tok    = word_tok;
		s_v      = 1'b0;
		s_tok    = '0;
		if (end_of_source) begin
			if (mode_q == MODE_WORD) begin
				f_v   = 1'b1;
				f_tok = word_tok;
			end else if (mode_q == MODE_STRING) begin
				f_v   = 1'b1;
				f_tok = str_tok;
			end
			s_v        = 1'b1;
			s_tok.kind = KIND_END;
			s_tok.start = clip_pos(pos_q);
			s_tok.len  = '0;
			s_tok.endm = 1'b1;
			mode_d     = MODE_NORMAL;
			slash_d    = 1'b0;
			pos_d      = '0;
			tstart_d   = '0;
			tlen_d     = '0;
		end else begin
			pos_d = sat_inc(pos_q);
			unique case (mode_q) inside
				MODE_COMMENT: begin
					if (ch == CH_NL) begin
						mode_d = MODE_NORMAL;
					end
				end
				MODE_STRING: begin
					if (ch == CH_QUOTE) begin
						f_v    = 1'b1;
						f_tok  = str_tok;
						mode_d = MODE_NORMAL;
					end else begin
						tlen_d = sat_inc(tlen_q);
					end
				end
				MODE_NORMAL, MODE_WORD: begin
					// word continues or closes
					if (mode_q == MODE_WORD) begin
						if (is_word_byte(ch)) begin
							pre_we  = (tlen_q < POS_W'(KW_LEN));
							pre_idx = tlen_q[IDX_W-1:0];
							tlen_d  = sat_inc(tlen_q);
							handled = 1'b1;
						end else begin
							f_v    = 1'b1;
							f_tok  = word_tok;
							mode_d = MODE_NORMAL;
						end
					end
					// second slash opens a comment, else the slash is dropped
					if (!handled && slash_q) begin
						slash_d = 1'b0;
						if (ch == CH_SLASH) begin
							mode_d  = MODE_COMMENT;
							handled = 1'b1;
						end
					end
					// byte in normal mode
					if (!handled) begin
						if (ch == CH_SLASH) begin
							slash_d = 1'b1;
						end else if (ch == CH_QUOTE) begin
							mode_d   = MODE_STRING;
							tstart_d = sat_inc(pos_q);
							tlen_d   = '0;
						end else if (is_word_byte(ch)) begin
							mode_d   = MODE_WORD;
							tstart_d = pos_q;
							pre_we   = 1'b1;
							pre_idx  = '0;
							tlen_d   = POS_W'(1);
						end else if (!is_space_byte(ch) && pk[6]) begin
							s_v         = 1'b1;
							s_tok.kind  = pk[5:0];
							s_tok.start = clip_pos(pos_q);
							s_tok.len   = OUT_W'(1);
							s_tok.endm  = 1'b0;
						end
					end
				end
			endcase
		end
	end

	// queue entry: the first token always sits in slot zero
	assign q_wr         = acc && (f_v || s_v);
	assign q_data.two   = f_v && s_v;
	assign q_data.tok0  = f_v ? f_tok : s_tok;
	assign q_data.tok1  = s_tok;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			slash_q  <= 1'b0;
			pos_q    <= '0;
			tstart_q <= '0;
			tlen_q   <= '0;
		end else if (acc) begin
			mode_q   <= mode_d;
			slash_q  <= slash_d;
			pos_q    <= pos_d;
			tstart_q <= tstart_d;
			tlen_q   <= tlen_d;
		end
	end

	// word prefix buffer
	always_ff @(posedge clk) begin
		if (acc && pre_we) begin
			prefix_q[pre_idx] <= ch;
		end
	end

endmodule

// File: design/ktl_back.sv
// result back: splits queue entries into single items in an output register
module ktl_back import ktl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ktl_entry_t       q_data,
	input  ktl_qstat_t       q_stat,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [5:0]       kind,
	output logic [OUT_W-1:0] start_res,
	output logic [OUT_W-1:0] length,
	output logic             end_marker,
	output logic             last_in_run
);

	logic     out_v_q;
	logic     sub_q;
	ktl_tok_t out_tok_q;
	logic     out_last_q;
	logic     load;
	logic     take;
	logic     final_tok;

	// output register frees when empty or taken this cycle
	assign take      = pop && out_v_q;
	assign load      = !q_stat.empty && (!out_v_q || take);
	assign final_tok = !q_data.two || sub_q;
	assign q_rd      = load && final_tok;

	// control: output valid and slot within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				sub_q   <= !final_tok;
			end else if (take) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q  <= sub_q ? q_data.tok1 : q_data.tok0;
			out_last_q <= final_tok;
		end
	end

	assign empty       = !out_v_q;
	assign kind        = out_tok_q.kind;
	assign start_res   = out_tok_q.start;
	assign length      = out_tok_q.len;
	assign end_marker  = out_tok_q.endm;
	assign last_in_run = out_last_q;

endmodule

// File: design/keyword_token_lexer.sv
// top level of the keyword token lexer: front, token queue and back
//
// channel   direction  handshake          payload
// input     in         push / full        ch, end_of_source
// result    out        pop / empty        kind, start_res, length, end_marker, last_in_run
//
// one byte is taken every cycle while the token queue has room; the lexer
// state update and keyword compare finish in that cycle
// an item gives up to two results; the back sends one per cycle while results
// are popped, so the two results of an item leave the back one after the other
// a result passes through the token queue and then the output register
// the four-entry token queue lets input run on while results stall
// arst_n clears mode, counters, queue and output register at once
`include "keyword_token_lexer_defines.svh"
module keyword_token_lexer import ktl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       ch,
	input  logic             end_of_source,
	input  logic             pop,
	output logic             empty,
	output logic [5:0]       kind,
	output logic [OUT_W-1:0] start_res,
	output logic [OUT_W-1:0] length,
	output logic             end_marker,
	output logic             last_in_run
);

	ktl_qstat_t q_stat;
	logic       q_wr;
	logic       q_rd;
	ktl_entry_t q_wdata;
	ktl_entry_t q_rdata;

	assign full = q_stat.full;

	// lexer front
	ktl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.ch            (ch),
		.end_of_source (end_of_source),
		.q_stat        (q_stat),
		.q_wr          (q_wr),
		.q_data        (q_wdata)
	);

	// token queue
	ktl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wdata),
		.rd      (q_rd),
		.rd_data (q_rdata),
		.stat    (q_stat)
	);

	// result back
	ktl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (q_rdata),
		.q_stat      (q_stat),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.start_res   (start_res),
		.length      (length),
		.end_marker  (end_marker),
		.last_in_run (last_in_run)
	);

	// checks
	`KTL_ASSERT_SAME(a_end_is_last, !empty && end_marker, last_in_run && length == '0, "end item not last or not empty")
	`KTL_ASSERT_SAME(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty), "token queue both full and empty")
	`KTL_ASSERT_NEXT(a_end_queued, push && !full && end_of_source, !q_stat.empty, "end item did not reach the queue")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the keyword token lexer
`timescale 1ns / 100ps

module testbench;
	import ktl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 10;

	// one token as the lexer should emit it
	typedef struct {
		logic [5:0]       kind;
		logic [OUT_W-1:0] start;
		logic [OUT_W-1:0] len;
		logic             endm;
		logic             last;
	} token_t;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	logic [7:0]       ch;
	logic             end_of_source;
	logic             pop;
	logic             empty;
	logic [5:0]       kind;
	logic [OUT_W-1:0] start_res;
	logic [OUT_W-1:0] length;
	logic             end_marker;
	logic             last_in_run;

	// tokens still owed by the lexer, oldest first
	token_t pending_tokens[$];

	int error_count = 0;
	int items_sent  = 0;
	int idle_cycles = 0;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_request = 1'b0;

	// mirror of the lexer state
	logic [1:0]       lx_mode;
	logic             lx_slash;
	logic [POS_W-1:0] lx_pos;
	logic [POS_W-1:0] lx_tstart;
	logic [POS_W-1:0] lx_tlen;
	logic [7:0]       lx_prefix [KW_LEN];

	// keyword spellings and their kinds
	string kw_names [NUM_KW] = '{
		"pulse", "global", "shadow", "atom", "beam", "quantum", "vortex", "void",
		"synapse", "bypass", "chronos", "ether", "scan", "matrix", "~link", "fusion",
		"@NeuralComposition", "Signal", "Vision", "Orbit", "Trigger", "Z_Plane", "Input"
	};
	int kw_kinds [NUM_KW] = '{
		12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 27, 28, 29,
		30, 31, 32, 33
	};
	string punct_chars   = "{}[]():,=";
	string word_alphabet =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.~@#";

	keyword_token_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ch           (ch),
		.end_of_source(end_of_source),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.start_res    (start_res),
		.length       (length),
		.end_marker   (end_marker),
		.last_in_run  (last_in_run)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// lexer prediction
	// ---------------------------------------------------------------

	function automatic logic [POS_W-1:0] sat_step(input logic [POS_W-1:0] v);
		return (v == {POS_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_W-1:0] clip_out(input logic [POS_W-1:0] v);
		return (v > POS_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(v);
	endfunction

	function automatic token_t make_token(input logic [5:0] k, input logic [POS_W-1:0] s,
		input logic [POS_W-1:0] n, input logic e);
		token_t t;
		t.kind  = k;
		t.start = clip_out(s);
		t.len   = clip_out(n);
		t.endm  = e;
		t.last  = 1'b0;
		return t;
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == "_" || c == "." || c == "~" ||
			c == "@" || c == "#";
	endfunction

	// keyword, else number or identifier, from the kept prefix
	function automatic logic [5:0] word_class();
		string name;
		logic  hit;
		for (int w = 0; w < NUM_KW; w++) begin
			name = kw_names[w];
			if (lx_tlen == name.len()) begin
				hit = 1'b1;
				for (int i = 0; i < name.len(); i++)
					if (lx_prefix[i] != name[i])
						hit = 1'b0;
				if (hit)
					return 6'(kw_kinds[w]);
			end
		end
		if (lx_prefix[0] >= "0" && lx_prefix[0] <= "9")
			return KIND_NUMBER;
		return KIND_IDENT;
	endfunction

	function automatic void clear_lexer();
		lx_mode   = MODE_NORMAL;
		lx_slash  = 1'b0;
		lx_pos    = '0;
		lx_tstart = '0;
		lx_tlen   = '0;
	endfunction

	// advance the mirror by one item and queue the tokens it gives
	task automatic predict_tokens(input logic [7:0] c, input logic eos);
		token_t           run [2];
		int               n_run;
		logic [POS_W-1:0] p;
		logic             taken;
		p     = lx_pos;
		taken = 1'b0;
		n_run = 0;
		if (eos) begin
			// flush the open word or string, then the end marker
			if (lx_mode == MODE_WORD) begin
				run[n_run] = make_token(word_class(), lx_tstart, lx_tlen, 1'b0);
				n_run++;
			end else if (lx_mode == MODE_STRING) begin
				run[n_run] = make_token(KIND_STRING, lx_tstart, lx_tlen, 1'b0);
				n_run++;
			end
			run[n_run] = make_token(KIND_END, lx_pos, '0, 1'b1);
			n_run++;
			clear_lexer();
		end else begin
			lx_pos = sat_step(lx_pos);
			if (lx_mode == MODE_COMMENT) begin
				if (c == CH_NL)
					lx_mode = MODE_NORMAL;
			end else if (lx_mode == MODE_STRING) begin
				if (c == CH_QUOTE) begin
					run[n_run] = make_token(KIND_STRING, lx_tstart, lx_tlen, 1'b0);
					n_run++;
					lx_mode = MODE_NORMAL;
				end else begin
					lx_tlen = sat_step(lx_tlen);
				end
			end else begin
				// a word grows or closes; a closing byte is then lexed afresh
				if (lx_mode == MODE_WORD) begin
					if (is_word_char(c)) begin
						if (lx_tlen < KW_LEN)
							lx_prefix[lx_tlen] = c;
						lx_tlen = sat_step(lx_tlen);
						taken   = 1'b1;
					end else begin
						run[n_run] = make_token(word_class(), lx_tstart, lx_tlen, 1'b0);
						n_run++;
						lx_mode = MODE_NORMAL;
					end
				end
				// second slash opens a comment, anything else drops the first
				if (!taken && lx_slash) begin
					lx_slash = 1'b0;
					if (c == CH_SLASH) begin
						lx_mode = MODE_COMMENT;
						taken   = 1'b1;
					end
				end
				if (!taken) begin
					if (c == CH_SLASH) begin
						lx_slash = 1'b1;
					end else if (c == CH_QUOTE) begin
						lx_mode   = MODE_STRING;
						lx_tstart = sat_step(p);
						lx_tlen   = '0;
					end else if (is_word_char(c)) begin
						lx_mode      = MODE_WORD;
						lx_tstart    = p;
						lx_prefix[0] = c;
						lx_tlen      = POS_W'(1);
					end else begin
						for (int k = 0; k < 9; k++)
							if (punct_chars[k] == c) begin
								run[n_run] = make_token(6'(k), p, POS_W'(1), 1'b0);
								n_run++;
							end
					end
				end
			end
		end
		if (n_run != 0)
			run[n_run - 1].last = 1'b1;
		for (int i = 0; i < n_run; i++)
			pending_tokens.insert(pending_tokens.size(), run[i]);
	endtask

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------

	// offer one item, with random gaps, until the lexer takes it
	task automatic send_item(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push          <= 1'b1;
		ch            <= c;
		end_of_source <= eos;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_tokens(c, eos);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_item(8'($urandom), 1'b1);
	endtask

	function automatic logic [7:0] word_char();
		return word_alphabet[$urandom_range(0, word_alphabet.len() - 1)];
	endfunction

	function automatic logic [7:0] blank_char();
		int n;
		n = $urandom_range(0, 5);
		return (n == 0) ? " " : 8'(8 + n);
	endfunction

	task automatic send_word(input int n, input logic [7:0] first);
		send_item(first, 1'b0);
		repeat (n - 1)
			send_item(word_char(), 1'b0);
	endtask

	// one source: a run of random fragments closed by an end item
	task automatic send_random_source();
		int    frags;
		int    sel;
		string name;
		frags = $urandom_range(1, 10);
		repeat (frags) begin
			sel = $urandom_range(0, 19);
			if (sel <= 3) begin
				send_text(kw_names[$urandom_range(0, NUM_KW - 1)]);
			end else if (sel == 4) begin
				// near miss on a keyword: one byte short or one too many
				name = kw_names[$urandom_range(0, NUM_KW - 1)];
				if ($urandom_range(1))
					send_text(name.substr(0, name.len() - 2));
				else begin
					send_text(name);
					send_item(word_char(), 1'b0);
				end
			end else if (sel <= 6) begin
				send_word($urandom_range(1, 8), 8'("a" + $urandom_range(0, 25)));
			end else if (sel == 7) begin
				send_word($urandom_range(1, 6), 8'("0" + $urandom_range(0, 9)));
			end else if (sel <= 9) begin
				send_item(CH_QUOTE, 1'b0);
				repeat ($urandom_range(0, 8))
					send_item(8'($urandom), 1'b0);
				if ($urandom_range(9) != 0)
					send_item(CH_QUOTE, 1'b0);
			end else if (sel == 10) begin
				send_text("//");
				repeat ($urandom_range(0, 6))
					send_item(8'($urandom), 1'b0);
				if ($urandom_range(9) != 0)
					send_item(CH_NL, 1'b0);
			end else if (sel <= 13) begin
				send_item(punct_chars[$urandom_range(0, 8)], 1'b0);
			end else if (sel <= 15) begin
				send_item(blank_char(), 1'b0);
			end else if (sel == 16) begin
				send_item(CH_SLASH, 1'b0);
			end else if (sel == 17) begin
				send_item(8'($urandom_range(0, 255)), 1'b0);
			end else if (sel == 18) begin
				send_item(8'($urandom_range(128, 255)), 1'b0);
			end else begin
				send_word($urandom_range(19, 30), word_char());
			end
			if ($urandom_range(1))
				send_item(blank_char(), 1'b0);
		end
		send_end();
	endtask

	// ---------------------------------------------------------------
	// output side
	// ---------------------------------------------------------------

	// receiver: random pop, with a long hold-off on request
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// compare each popped token with the oldest prediction
	always @(posedge clk) begin : check_tokens
		token_t want;
		if (arst_n && pop && !empty) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: token with none expected, expected nothing, actual kind %0d",
					$time, kind);
				error_count++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("kind", 16'(want.kind), 16'(kind));
				check_field("start_res", 16'(want.start), 16'(start_res));
				check_field("length", 16'(want.len), 16'(length));
				check_field("end_marker", 16'(want.endm), 16'(end_marker));
				check_field("last_in_run", 16'(want.last), 16'(last_in_run));
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// punctuation, keyword closed by a byte, edge bytes, slashes and comments,
	// unterminated string
	task automatic test_directed();
		send_text("{}[]():,=");
		send_end();
		send_text("void(");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_text("/x//z");
		send_end();
		send_item(CH_QUOTE, 1'b0);
		send_text("a");
		send_end();
	endtask

	task automatic test_random_sources(input int target);
		int first;
		first = items_sent;
		while (items_sent - first < target)
			send_random_source();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		int first;
		first        = items_sent;
		hold_request = 1'b1;
		while (items_sent - first < 80)
			send_random_source();
	endtask

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		ch            = 8'h00;
		end_of_source = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 75;
		clear_lexer();
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_sources(520);
		send_idle_pct = 75;
		recv_idle_pct = 14;
		test_random_sources(520);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sources(520);
		test_backpressure();

		// drain what is still owed
		push <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/ktl_pkg.sv
design/ktl_fifo.sv
design/ktl_front.sv
design/ktl_back.sv
design/keyword_token_lexer.sv
tb/sv/testbench.sv
